// ===== rtl/fat_chain_allocator_top_assert.svh =====
// Assertion macros for the chain allocator top level.
// Included by fat_chain_allocator_top.sv; no other dependencies.
`ifndef FAT_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FCA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fca assertion failed");

// consequent checked in the cycle after the antecedent
`define FCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fca assertion failed");

`endif

// ===== rtl/fca_pkg.sv =====
// Shared types, codes and constants for the chain allocator.
// No dependencies.
package fca_pkg;

    localparam int TBL_ENTRIES_DEF = 4096;
    localparam int BIU_W           = 13;
    localparam logic [BIU_W-1:0] BIU_RESET = 13'd4096;
    localparam int BLK_W           = 12;
    localparam int TDATA_W         = 32;

    // operation codes
    localparam logic [2:0] FUNC_ALLOC    = 3'd0;
    localparam logic [2:0] FUNC_NEXT     = 3'd1;
    localparam logic [2:0] FUNC_EXTEND   = 3'd2;
    localparam logic [2:0] FUNC_FREE     = 3'd3;
    localparam logic [2:0] FUNC_TRUNCATE = 3'd4;
    localparam logic [2:0] FUNC_WALK     = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // datapath commands
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_CLR      = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd2;
    localparam logic [OP_W-1:0] OP_RD_BLK   = 5'd3;
    localparam logic [OP_W-1:0] OP_START    = 5'd4;
    localparam logic [OP_W-1:0] OP_FOL_RD   = 5'd5;
    localparam logic [OP_W-1:0] OP_STEP     = 5'd6;
    localparam logic [OP_W-1:0] OP_DEAD     = 5'd7;
    localparam logic [OP_W-1:0] OP_RES_CUR  = 5'd8;
    localparam logic [OP_W-1:0] OP_SET_END  = 5'd9;
    localparam logic [OP_W-1:0] OP_REST     = 5'd10;
    localparam logic [OP_W-1:0] OP_REST0    = 5'd11;
    localparam logic [OP_W-1:0] OP_TRUNC    = 5'd12;
    localparam logic [OP_W-1:0] OP_FREE_RD  = 5'd13;
    localparam logic [OP_W-1:0] OP_FREE_CHK = 5'd14;
    localparam logic [OP_W-1:0] OP_SCAN_RD  = 5'd15;
    localparam logic [OP_W-1:0] OP_SCAN_NXT = 5'd16;
    localparam logic [OP_W-1:0] OP_LINK     = 5'd17;
    localparam logic [OP_W-1:0] OP_ALLOC    = 5'd18;
    localparam logic [OP_W-1:0] OP_FULL     = 5'd19;
    localparam logic [OP_W-1:0] OP_BAD      = 5'd20;
    localparam logic [OP_W-1:0] OP_EMIT     = 5'd21;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       blk_bad;
        logic       cnt_zero;
        logic       rdata_zero;
        logic       rdata_link;
        logic       ce_end;
        logic       steps_zero;
        logic       scan_done;
        logic       ptr_zero;
        logic       cur_zero;
        logic       clr_last;
        logic       out_free;
    } stat_t;

endpackage

// ===== rtl/fca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fca_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fca_datapath.sv =====
// Datapath of the chain allocator: link table RAM, pointers, counters, result register.
// Depends on fca_pkg and fca_ram.
module fca_datapath import fca_pkg::*; #(
    parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [BIU_W-1:0]   cfg_wdata,
    input  logic [TDATA_W-1:0] s_tdata,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = AW + 1;
    localparam logic [EW-1:0] LINK_END = EW'(2 * TABLE_ENTRIES - 1);
    localparam logic [31:0]   TE32     = 32'(TABLE_ENTRIES);

    logic [BIU_W-1:0] biu_reg, biu_next;
    logic [2:0]       func_reg, func_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [BLK_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [EW-1:0]    ce_reg, ce_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [AW:0]      scan_reg, scan_next;
    logic [BLK_W-1:0] steps_reg, steps_next;
    logic [AW-1:0]    res_reg, res_next;
    logic             end_reg, end_next;
    logic [1:0]       st_reg, st_next;
    logic [BLK_W-1:0] freed_reg, freed_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0] m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, rdata;

    logic [31:0]   blk32, biu32, lim32, res32;
    logic [AW-1:0] blk_a;
    logic [AW:0]   lim;

    fca_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign blk32 = 32'(blk_reg);
    assign blk_a = blk32[AW-1:0];
    assign biu32 = 32'(biu_reg);
    // free search never looks past the table
    assign lim32 = (biu32 > TE32) ? TE32 : biu32;
    assign lim   = lim32[AW:0];
    assign res32 = 32'(res_reg);

    always_comb begin
        stat.func       = func_reg;
        stat.blk_bad    = (blk_reg == '0) || (blk32 >= TE32);
        stat.cnt_zero   = (cnt_reg == '0);
        stat.rdata_zero = (rdata == '0);
        stat.rdata_link = (32'(rdata) < TE32);
        stat.ce_end     = (32'(ce_reg) >= TE32);
        stat.steps_zero = (steps_reg == '0);
        stat.scan_done  = (scan_reg >= lim);
        stat.ptr_zero   = (ptr_reg == '0);
        stat.cur_zero   = (cur_reg == '0);
        stat.clr_last   = (clr_reg == AW'(TABLE_ENTRIES - 1));
        stat.out_free   = !m_valid_reg || m_tready;
    end

    always_comb begin
        biu_next     = biu_reg;
        func_next    = func_reg;
        blk_next     = blk_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        ce_next      = ce_reg;
        ptr_next     = ptr_reg;
        scan_next    = scan_reg;
        steps_next   = steps_reg;
        res_next     = res_reg;
        end_next     = end_reg;
        st_next      = st_reg;
        freed_next   = freed_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        if (cfg_we) begin
            biu_next = cfg_wdata;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (cmd.op)
            OP_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            OP_LOAD: begin
                func_next  = s_tdata[2:0];
                blk_next   = s_tdata[14:3];
                cnt_next   = s_tdata[26:15];
                res_next   = '0;
                end_next   = 1'b0;
                st_next    = ST_OK;
                freed_next = '0;
                scan_next  = (AW+1)'(1);
            end
            OP_RD_BLK: ram_raddr = blk_a;
            OP_START: begin
                cur_next = blk_a;
                ce_next  = rdata;
                ptr_next = blk_a;
                if (func_reg == FUNC_WALK) begin
                    steps_next = cnt_reg;
                end else if (func_reg == FUNC_TRUNCATE) begin
                    steps_next = cnt_reg - 12'd1;
                end else begin
                    steps_next = 12'd1;
                end
            end
            OP_FOL_RD: ram_raddr = ce_reg[AW-1:0];
            OP_STEP: begin
                cur_next   = ce_reg[AW-1:0];
                ce_next    = rdata;
                steps_next = steps_reg - 12'd1;
            end
            OP_DEAD: cur_next = '0;
            OP_RES_CUR: begin
                res_next = cur_reg;
                end_next = (cur_reg == '0);
            end
            OP_SET_END: end_next = 1'b1;
            OP_REST: ptr_next = (rdata == '0) ? '0 : ce_reg[AW-1:0];
            OP_REST0: ptr_next = '0;
            OP_TRUNC: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = LINK_END;
                res_next  = cur_reg;
            end
            OP_FREE_RD: ram_raddr = ptr_reg;
            OP_FREE_CHK: begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                freed_next = freed_reg + 12'd1;
                ptr_next   = stat.rdata_link ? rdata[AW-1:0] : '0;
            end
            OP_SCAN_RD: ram_raddr = scan_reg[AW-1:0];
            OP_SCAN_NXT: scan_next = scan_reg + 1'b1;
            OP_LINK: begin
                ram_we    = 1'b1;
                ram_waddr = blk_a;
                ram_wdata = {1'b0, scan_reg[AW-1:0]};
            end
            OP_ALLOC: begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[AW-1:0];
                ram_wdata = LINK_END;
                res_next  = scan_reg[AW-1:0];
            end
            OP_FULL: begin
                st_next  = ST_FULL;
                end_next = (func_reg == FUNC_EXTEND);
            end
            OP_BAD: st_next = ST_BAD;
            OP_EMIT: begin
                m_valid_next = 1'b1;
                m_data_next  = {5'b0, freed_reg, st_reg, end_reg, res32[BLK_W-1:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            biu_reg     <= BIU_RESET;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            biu_reg     <= biu_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        blk_reg    <= blk_next;
        cnt_reg    <= cnt_next;
        cur_reg    <= cur_next;
        ce_reg     <= ce_next;
        ptr_reg    <= ptr_next;
        scan_reg   <= scan_next;
        steps_reg  <= steps_next;
        res_reg    <= res_next;
        end_reg    <= end_next;
        st_reg     <= st_next;
        freed_reg  <= freed_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/fca_ctrl.sv =====
// Sequencer of the chain allocator: issues at most one datapath command per cycle.
// Depends on fca_pkg.
module fca_ctrl import fca_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_VCHK  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_WDONE = 4'd6;
    localparam logic [3:0] S_TR    = 4'd7;
    localparam logic [3:0] S_TRCHK = 4'd8;
    localparam logic [3:0] S_TRWR  = 4'd9;
    localparam logic [3:0] S_FRRD  = 4'd10;
    localparam logic [3:0] S_FRCHK = 4'd11;
    localparam logic [3:0] S_SRRD  = 4'd12;
    localparam logic [3:0] S_SRCHK = 4'd13;
    localparam logic [3:0] S_ALLOC = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLR;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                priority if (stat.func == FUNC_ALLOC) begin
                    state_next = S_SRRD;
                end else if (stat.func > FUNC_WALK || stat.blk_bad) begin
                    cmd.op     = OP_BAD;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_RD_BLK;
                    state_next = S_VCHK;
                end
            end
            S_VCHK: begin
                if (stat.rdata_zero) begin
                    cmd.op     = OP_BAD;
                    state_next = S_DONE;
                end else begin
                    cmd.op = OP_START;
                    if (stat.func == FUNC_FREE ||
                        (stat.func == FUNC_TRUNCATE && stat.cnt_zero)) begin
                        state_next = S_FRRD;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                priority if (stat.steps_zero) begin
                    state_next = S_WDONE;
                end else if (stat.ce_end) begin
                    cmd.op     = OP_DEAD;
                    state_next = S_WDONE;
                end else begin
                    cmd.op     = OP_FOL_RD;
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                // a link into a free block ends the chain
                if (stat.rdata_zero) begin
                    cmd.op     = OP_DEAD;
                    state_next = S_WDONE;
                end else begin
                    cmd.op     = OP_STEP;
                    state_next = S_WALK;
                end
            end
            S_WDONE: begin
                priority if (stat.func == FUNC_TRUNCATE) begin
                    if (stat.cur_zero) begin
                        cmd.op     = OP_SET_END;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_TR;
                    end
                end else if (stat.func == FUNC_EXTEND && stat.cur_zero) begin
                    state_next = S_SRRD;
                end else begin
                    cmd.op     = OP_RES_CUR;
                    state_next = S_DONE;
                end
            end
            S_TR: begin
                if (stat.ce_end) begin
                    cmd.op     = OP_REST0;
                    state_next = S_TRWR;
                end else begin
                    cmd.op     = OP_FOL_RD;
                    state_next = S_TRCHK;
                end
            end
            S_TRCHK: begin
                cmd.op     = OP_REST;
                state_next = S_TRWR;
            end
            S_TRWR: begin
                cmd.op     = OP_TRUNC;
                state_next = stat.ptr_zero ? S_DONE : S_FRRD;
            end
            S_FRRD: begin
                cmd.op     = OP_FREE_RD;
                state_next = S_FRCHK;
            end
            S_FRCHK: begin
                if (stat.rdata_zero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_FREE_CHK;
                    state_next = stat.rdata_link ? S_FRRD : S_DONE;
                end
            end
            S_SRRD: begin
                if (stat.scan_done) begin
                    cmd.op     = OP_FULL;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_SRCHK;
                end
            end
            S_SRCHK: begin
                priority if (!stat.rdata_zero) begin
                    cmd.op     = OP_SCAN_NXT;
                    state_next = S_SRRD;
                end else if (stat.func == FUNC_EXTEND) begin
                    cmd.op     = OP_LINK;
                    state_next = S_ALLOC;
                end else begin
                    cmd.op     = OP_ALLOC;
                    state_next = S_DONE;
                end
            end
            S_ALLOC: begin
                cmd.op     = OP_ALLOC;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/fat_chain_allocator_top.sv =====
// Chain allocator: a file allocation table of linked block chains.
// Input beats carry one operation; each yields exactly one result beat.
// s_tdata: func, chain_block, link_count from bit 0 up.
// m_tdata: result_block, at_end, status, freed_count from bit 0 up.
// cfg_we/cfg_wdata write blocks_in_use, the free-search limit; write only when idle.
// After reset the table is cleared one entry a cycle, all TABLE_ENTRIES entries,
// with s_tready low; configuration writes are still taken.
// One operation at a time. Every link followed, every entry probed by the
// lowest-free search and every block freed is one read of the table RAM,
// which has one write port and one read port.
// s_tready comes back the cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, the next item
// is still accepted and runs up to its own result, then waits for m_tready.
// Depends on fca_pkg, fca_ctrl, fca_datapath, fca_ram and fat_chain_allocator_top_assert.svh.
module fat_chain_allocator_top import fca_pkg::*; #(
    parameter int TABLE_ENTRIES = TBL_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [BIU_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // func[2:0], chain_block[14:3], link_count[26:15]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // result_block[11:0], at_end[12], status[14:13],
                                          // freed_count[26:15]
);

    cmd_t  cmd;
    stat_t stat;

    fca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fca_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`include "fat_chain_allocator_top_assert.svh"

    `FCA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `FCA_ASSERT_SAME(a_status_code, aclk, aresetn, m_tvalid,
        m_tdata[14:13] == ST_OK || m_tdata[14:13] == ST_FULL || m_tdata[14:13] == ST_BAD)
    `FCA_ASSERT_SAME(a_bad_is_empty, aclk, aresetn, m_tvalid && m_tdata[14:13] == ST_BAD,
        m_tdata[11:0] == '0 && !m_tdata[12] && m_tdata[26:15] == '0)
    `FCA_ASSERT_SAME(a_full_no_block, aclk, aresetn, m_tvalid && m_tdata[14:13] == ST_FULL,
        m_tdata[11:0] == '0 && m_tdata[26:15] == '0)

endmodule

// ===== tb/sv/fat_chain_allocator_top_tb.sv =====
// Self-checking testbench for fat_chain_allocator_top: random stream traffic on both sides,
// results predicted by a local copy of the link table. Depends on fca_pkg and the RTL.
`timescale 1ns / 100ps

module fat_chain_allocator_top_tb;
    import fca_pkg::*;

    localparam int        ENTRIES    = 4096;
    localparam logic [12:0] LINK_END = 13'h1FFF;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    typedef struct packed {
        logic [11:0] blk;
        logic        at_end;
        logic [1:0]  status;
        logic [11:0] freed;
    } alloc_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [BIU_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    fat_chain_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // shadow table and free-search limit
    logic [12:0]   fat_shadow [ENTRIES];
    logic [12:0]   search_limit;
    logic [31:0]   op_pending[$];
    alloc_result_t result_expected[$];
    bit            tx_burst = 1'b0;
    bit            rx_burst = 1'b0;
    int            n_errors = 0;
    int            n_checked = 0;
    int            n_accepted = 0;
    int            n_full = 0;
    int            n_bad = 0;
    logic [12:0]   limits [6] = '{13'd40, 13'd2, 13'd8191, 13'd0, 13'd1, 13'd24};
    int            counts [6] = '{70, 20, 80, 20, 20, 60};

    function automatic logic [11:0] next_link(logic [11:0] b);
        logic [12:0] e;
        if (b == 0) return 0;
        e = fat_shadow[b];
        if (e == 0 || e >= ENTRIES) return 0;
        if (fat_shadow[e[11:0]] == 0) return 0;   // dangling link ends the chain
        return e[11:0];
    endfunction

    function automatic logic [11:0] lowest_free();
        int lim;
        lim = (search_limit > ENTRIES) ? ENTRIES : search_limit;
        for (int i = 1; i < lim; i++)
            if (fat_shadow[i] == 0) return i[11:0];
        return 0;
    endfunction

    function automatic int release_chain(logic [11:0] b);
        int          cnt;
        logic [12:0] e;
        cnt = 0;
        while (b != 0 && fat_shadow[b] != 0) begin
            e = fat_shadow[b];
            fat_shadow[b] = 0;
            cnt++;
            b = (e < ENTRIES) ? e[11:0] : 12'd0;
        end
        return cnt;
    endfunction

    function automatic alloc_result_t predict_op(logic [31:0] beat);
        alloc_result_t r;
        logic [2:0]    fn;
        logic [11:0]   blk, cnt, cur, nb, rest;
        bit            ok;
        fn  = beat[2:0];
        blk = beat[14:3];
        cnt = beat[26:15];
        r   = '0;
        ok  = blk != 0 && fat_shadow[blk] != 0;
        if (fn == FUNC_ALLOC) begin
            nb = lowest_free();
            if (nb == 0) r.status = ST_FULL;
            else begin
                fat_shadow[nb] = LINK_END;
                r.blk = nb;
            end
        end else if (fn > FUNC_WALK || !ok) begin
            r.status = ST_BAD;
        end else begin
            case (fn)
                FUNC_NEXT: begin
                    r.blk = next_link(blk);
                    r.at_end = r.blk == 0;
                end
                FUNC_EXTEND: begin
                    r.blk = next_link(blk);
                    if (r.blk == 0) begin
                        nb = lowest_free();
                        if (nb == 0) begin
                            r.status = ST_FULL;
                            r.at_end = 1'b1;
                        end else begin
                            fat_shadow[blk] = {1'b0, nb};
                            fat_shadow[nb] = LINK_END;
                            r.blk = nb;
                        end
                    end
                end
                FUNC_FREE: r.freed = 12'(release_chain(blk));
                FUNC_TRUNCATE: begin
                    if (cnt == 0) r.freed = 12'(release_chain(blk));
                    else begin
                        cur = blk;
                        for (int i = 1; i < cnt && cur != 0; i++) cur = next_link(cur);
                        if (cur == 0) r.at_end = 1'b1;
                        else begin
                            rest = next_link(cur);
                            fat_shadow[cur] = LINK_END;
                            r.freed = 12'(release_chain(rest));
                            r.blk = cur;
                        end
                    end
                end
                default: begin   // walk
                    cur = blk;
                    for (int i = 0; i < cnt && cur != 0; i++) cur = next_link(cur);
                    r.blk = cur;
                    r.at_end = cur == 0;
                end
            endcase
        end
        return r;
    endfunction

    function automatic int pick_gap(bit burst);
        int p;
        if (burst) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender
    int tx_gap = 0;
    always @(posedge aclk) begin
        alloc_result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                r = predict_op(s_tdata);
                result_expected.push_back(r);
                n_accepted++;
            end
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (op_pending.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= op_pending.pop_front();
                tx_gap <= pick_gap(tx_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    int rx_gap = 0;
    always @(posedge aclk) begin
        alloc_result_t exp_r, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[11:0], m_tdata[12], m_tdata[14:13], m_tdata[26:15]};
                if (result_expected.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected result beat %h", m_tdata);
                end else begin
                    exp_r = result_expected.pop_front();
                    n_checked++;
                    if (got.status == ST_FULL) n_full++;
                    if (got.status == ST_BAD) n_bad++;
                    if (got !== exp_r) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"ERROR: result %0d blk %0d/%0d end %0d/%0d",
                                      " st %0d/%0d freed %0d/%0d (exp/act)"},
                                     n_checked, exp_r.blk, got.blk, exp_r.at_end, got.at_end,
                                     exp_r.status, got.status, exp_r.freed, got.freed);
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap <= pick_gap(rx_burst);
            end
        end
    end

    function automatic logic [31:0] pack_op(logic [2:0] fn, logic [11:0] blk, logic [11:0] cnt);
        return {5'b0, cnt, blk, fn};
    endfunction

    // mostly blocks that are live in the shadow table
    function automatic logic [11:0] pick_block();
        logic [11:0] b;
        b = 1;
        for (int i = 0; i < 8; i++) begin
            b = 12'($urandom_range(1, 48));
            if (fat_shadow[b] != 0) return b;
        end
        return b;
    endfunction

    task automatic wait_drained();
        while (op_pending.size() > 0 || s_tvalid || result_expected.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_limit(logic [12:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        search_limit = v;
    endtask

    task automatic queue_random(int n);
        int          p;
        logic [2:0]  fn;
        logic [11:0] blk, cnt;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < 20) fn = FUNC_ALLOC;
            else if (p < 42) fn = FUNC_EXTEND;
            else if (p < 52) fn = FUNC_NEXT;
            else if (p < 64) fn = FUNC_FREE;
            else if (p < 78) fn = FUNC_TRUNCATE;
            else if (p < 92) fn = FUNC_WALK;
            else fn = 3'($urandom_range(0, 7));
            blk = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) : pick_block();
            cnt = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(0, 6));
            op_pending.push_back(pack_op(fn, blk, cnt));
            if (op_pending.size() > 4) begin
                while (op_pending.size() > 1) @(posedge aclk);
                if ($urandom_range(0, 15) == 0) tx_burst = ~tx_burst;
                if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) fat_shadow[i] = 0;
        search_limit = BIU_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        write_limit(13'd4096);

        // chain building, dangling link, short walk/truncate, bad requests
        op_pending.push_back(pack_op(FUNC_ALLOC, 0, 0));        // -> 1
        op_pending.push_back(pack_op(FUNC_ALLOC, 4095, 4095));  // -> 2
        op_pending.push_back(pack_op(FUNC_EXTEND, 1, 0));       // 1 -> 3
        op_pending.push_back(pack_op(FUNC_EXTEND, 3, 0));       // 3 -> 4
        op_pending.push_back(pack_op(FUNC_EXTEND, 1, 0));       // follows, no append
        op_pending.push_back(pack_op(FUNC_NEXT, 1, 0));
        op_pending.push_back(pack_op(FUNC_WALK, 1, 2));
        op_pending.push_back(pack_op(FUNC_WALK, 1, 4095));
        op_pending.push_back(pack_op(FUNC_WALK, 1, 0));
        op_pending.push_back(pack_op(FUNC_TRUNCATE, 1, 5));
        op_pending.push_back(pack_op(FUNC_TRUNCATE, 1, 2));
        op_pending.push_back(pack_op(FUNC_FREE, 3, 0));         // leaves 1 dangling
        op_pending.push_back(pack_op(FUNC_NEXT, 1, 0));
        op_pending.push_back(pack_op(FUNC_WALK, 1, 1));
        op_pending.push_back(pack_op(FUNC_EXTEND, 1, 0));
        op_pending.push_back(pack_op(FUNC_TRUNCATE, 1, 0));
        op_pending.push_back(pack_op(FUNC_NEXT, 0, 0));
        op_pending.push_back(pack_op(FUNC_WALK, 4095, 4095));
        op_pending.push_back(pack_op(FUNC_FREE, 1, 0));
        op_pending.push_back(pack_op(FUNC_RSVD6, 2, 1));
        op_pending.push_back(pack_op(FUNC_RSVD7, 4095, 4095));
        op_pending.push_back(pack_op(FUNC_FREE, 2, 0));
        wait_drained();

        queue_random(80);
        wait_drained();             // sender holds off until all results are back
        queue_random(60);
        wait_drained();
        for (int k = 0; k < 6; k++) begin
            write_limit(limits[k]);
            if (limits[k] == 13'd2) begin
                op_pending.push_back(pack_op(FUNC_ALLOC, 0, 0));
                op_pending.push_back(pack_op(FUNC_ALLOC, 0, 0));
                op_pending.push_back(pack_op(FUNC_EXTEND, pick_block(), 0));
            end
            queue_random(counts[k]);
            wait_drained();
        end
        write_limit(13'd4096);
        queue_random(40);
        wait_drained();
        repeat (50) @(posedge aclk);

        $display("Covered %0d operations over search limits 0..8191 (%0d table-full, %0d rejected).",
                 n_accepted, n_full, n_bad);
        if (n_errors == 0 && result_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("ERROR: timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== fat_chain_allocator_top.f =====
+incdir+rtl
rtl/fca_pkg.sv
rtl/fca_ram.sv
rtl/fca_datapath.sv
rtl/fca_ctrl.sv
rtl/fat_chain_allocator_top.sv
tb/sv/fat_chain_allocator_top_tb.sv
